/* rtl/core/sha1c_pkg.sv */
// Package for the SHA-1 block compression engine.
// Holds the item and control types, the round constants and the mixing function.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package sha1c_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned CHAIN_DEPTH = 5;

	localparam logic [4:0] SUB_LAST = 5'd19;
	localparam logic [1:0] GRP_LAST = 2'd3;
	localparam logic [3:0] CNT_LAST = 4'd15;

	localparam logic [1:0] GRP_CHOOSE = 2'd0;
	localparam logic [1:0] GRP_MAJ = 2'd2;

	localparam logic [WORD_W-1:0] ROUND_K [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam logic [WORD_W-1:0] INIT_H [CHAIN_DEPTH] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef struct packed {
		logic [WORD_W-1:0] message_word;
		logic              start_message;
	} sha1c_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word0;
		logic [WORD_W-1:0] digest_word1;
		logic [WORD_W-1:0] digest_word2;
		logic [WORD_W-1:0] digest_word3;
		logic [WORD_W-1:0] digest_word4;
	} sha1c_out_t;

	typedef struct packed {
		logic       load_word;
		logic       init_chain;
		logic       begin_rounds;
		logic       round_en;
		logic       expand;
		logic [1:0] group;
		logic       finish;
	} sha1c_ctl_t;

	function automatic logic [WORD_W-1:0] sha1c_mix(
		input logic [1:0]        grp,
		input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] y,
		input logic [WORD_W-1:0] z
	);
		logic [WORD_W-1:0] r;
		unique case (grp)
			GRP_CHOOSE: r = (x & y) | (~x & z);
			GRP_MAJ:    r = (x & y) | (z & (x | y));
			default:    r = x ^ y ^ z;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/sha1_block_compression.sv */
// Top level of the SHA-1 block compression engine.
// Ties the sequencer, the message schedule and the round unit together.
// Depends on sha1c_pkg, sha1c_ctrl, sha1c_sched and sha1c_round.
//
//   channel   signals              handshake
//   -------   -------------------  ---------------------------------------
//   item in   item (sha1c_in_t)    taken at a clock edge with start & !busy
//   result    digest (sha1c_out_t) valid for the one cycle that done is high
//
// A word that does not end a block is taken and busy stays low.
// The sixteenth word starts 80 rounds, one per cycle through the shared round
// adder, and the final state then adds the result into the chaining value;
// done pulses in the same cycle that busy falls. Reset loads the standard
// initial chaining value and clears the word count. The receiver cannot stall,
// so done is never held.
`timescale 1ns / 1ps

module sha1_block_compression (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sha1c_pkg::sha1c_in_t  item,
	output logic                  busy,
	output logic                  done,
	output sha1c_pkg::sha1c_out_t digest
);
	import sha1c_pkg::*;

	sha1c_ctl_t        ctl;
	logic [WORD_W-1:0] wt;

	sha1c_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.start_message (item.start_message),
		.busy          (busy),
		.done          (done),
		.ctl           (ctl)
	);

	sha1c_sched u_sched (
		.clk          (clk),
		.ctl          (ctl),
		.message_word (item.message_word),
		.wt           (wt)
	);

	sha1c_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wt     (wt),
		.digest (digest)
	);

`ifndef ASSERT_OFF
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done raised while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy rose without a taken item");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a preceding busy phase");
`endif

endmodule

/* rtl/core/sha1c_ctrl.sv */
// Sequencer of the SHA-1 block compression engine.
// Counts incoming words, steps the 80 rounds in four groups and closes each block.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps

module sha1c_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  start_message,
	output logic                  busy,
	output logic                  done,
	output sha1c_pkg::sha1c_ctl_t ctl
);
	import sha1c_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} state_t;

	state_t     state_q;
	logic       busy_q;
	logic       done_q;
	logic [3:0] cnt_q;
	logic [1:0] group_q;
	logic [4:0] sub_q;

	logic       acc;
	logic [3:0] cnt_eff;
	logic       last_word;

	assign acc = start & ~busy_q;
	assign cnt_eff = start_message ? 4'd0 : cnt_q;
	assign last_word = (cnt_eff == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= 4'd0;
			group_q <= 2'd0;
			sub_q   <= 5'd0;
		end else begin
			done_q <= (state_q == ST_FINAL);
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= cnt_eff + 4'd1;
						if (last_word) begin
							state_q <= ST_ROUND;
							busy_q  <= 1'b1;
							group_q <= 2'd0;
							sub_q   <= 5'd0;
						end
					end
				end
				ST_ROUND: begin
					if (sub_q == SUB_LAST) begin
						sub_q <= 5'd0;
						if (group_q == GRP_LAST) begin
							state_q <= ST_FINAL;
						end else begin
							group_q <= group_q + 2'd1;
						end
					end else begin
						sub_q <= sub_q + 5'd1;
					end
				end
				ST_FINAL: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	always_comb begin
		ctl.load_word    = acc;
		ctl.init_chain   = acc & start_message;
		ctl.begin_rounds = acc & last_word;
		ctl.round_en     = (state_q == ST_ROUND);
		// The first sixteen rounds use the collected words as they are.
		ctl.expand       = !((group_q == GRP_CHOOSE) && !sub_q[4]);
		ctl.group        = group_q;
		ctl.finish       = (state_q == ST_FINAL);
	end

endmodule

/* rtl/core/sha1c_sched.sv */
// Message schedule of the SHA-1 block compression engine.
// A sixteen-word shift line collects the block and expands it one word per round.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps

module sha1c_sched (
	input  logic                          clk,
	input  sha1c_pkg::sha1c_ctl_t         ctl,
	input  logic [sha1c_pkg::WORD_W-1:0]  message_word,
	output logic [sha1c_pkg::WORD_W-1:0]  wt
);
	import sha1c_pkg::*;

	logic [WORD_W-1:0] win_q [WIN_DEPTH];
	logic [WORD_W-1:0] mixed;
	logic [WORD_W-1:0] shift_in;

	// The oldest word sits at the front, so the taps follow the round index.
	assign mixed = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign wt = ctl.expand ? {mixed[WORD_W-2:0], mixed[WORD_W-1]} : win_q[0];
	assign shift_in = ctl.round_en ? wt : message_word;

	always_ff @(posedge clk) begin
		if (ctl.load_word || ctl.round_en) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_DEPTH-1] <= shift_in;
		end
	end

endmodule

/* rtl/core/sha1c_round.sv */
// Round unit and chaining value of the SHA-1 block compression engine.
// One shared round adder updates the five working words once per cycle while the rounds run.
// Depends on sha1c_pkg.
`timescale 1ns / 1ps

module sha1c_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sha1c_pkg::sha1c_ctl_t         ctl,
	input  logic [sha1c_pkg::WORD_W-1:0]  wt,
	output sha1c_pkg::sha1c_out_t         digest
);
	import sha1c_pkg::*;

	logic [WORD_W-1:0] h_q [CHAIN_DEPTH];
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [WORD_W-1:0] nxt;

	assign nxt = {a_q[WORD_W-6:0], a_q[WORD_W-1:WORD_W-5]}
		+ sha1c_mix(ctl.group, b_q, c_q, d_q) + e_q + wt + ROUND_K[ctl.group];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_DEPTH; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctl.init_chain) begin
			for (int i = 0; i < CHAIN_DEPTH; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else if (ctl.finish) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.begin_rounds) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.round_en) begin
			a_q <= nxt;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WORD_W-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_comb begin
		digest.digest_word0 = h_q[0];
		digest.digest_word1 = h_q[1];
		digest.digest_word2 = h_q[2];
		digest.digest_word3 = h_q[3];
		digest.digest_word4 = h_q[4];
	end

endmodule

/* tb/sha1c_checker.sv */
// Checker for the SHA-1 block compression engine: tracks accepted items and digests.
// Predicts each block's chaining value and compares every digest field by field.
// Depends on sha1c_pkg for the item types, the round constants and the initial value.
`timescale 1ns / 1ps

module sha1c_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  sha1c_pkg::sha1c_in_t  item,
	input  logic                  done,
	input  sha1c_pkg::sha1c_out_t digest,
	output int                    fail_count,
	output int                    pending,
	output int                    words_seen,
	output int                    digests_seen
);

	import sha1c_pkg::*;

	logic [WORD_W-1:0] chain_h [CHAIN_DEPTH];
	logic [WORD_W-1:0] msg_win [WIN_DEPTH];
	logic [3:0]        fill;
	sha1c_out_t        digest_queue [$];
	int                fails = 0;
	int                n_words = 0;
	int                n_digests = 0;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	task automatic compress_window();
		logic [WORD_W-1:0] w [WIN_DEPTH];
		logic [WORD_W-1:0] a, b, c, d, e, wt, f, a_next;
		int g;
		w = msg_win;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int t = 0; t < 80; t++) begin
			g = t / 20;
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = rotl(w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16], 1);
				w[t % 16] = wt;
			end
			case (g[1:0])
				GRP_CHOOSE: f = (b & c) | (~b & d);
				GRP_MAJ: f = (b & c) | (b & d) | (c & d);
				default: f = b ^ c ^ d;
			endcase
			a_next = rotl(a, 5) + f + e + wt + ROUND_K[g];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = a_next;
		end
		chain_h[0] = chain_h[0] + a;
		chain_h[1] = chain_h[1] + b;
		chain_h[2] = chain_h[2] + c;
		chain_h[3] = chain_h[3] + d;
		chain_h[4] = chain_h[4] + e;
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %08h, got %08h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sha1c_out_t exp_d;
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_DEPTH; i++) chain_h[i] = INIT_H[i];
			for (int i = 0; i < WIN_DEPTH; i++) msg_win[i] = '0;
			fill = '0;
			digest_queue.delete();
		end else begin
			if (done) begin
				if (digest_queue.size() == 0) begin
					fails++;
					$display("%0t: digest %h with no block outstanding", $time, digest);
				end else begin
					exp_d = digest_queue.pop_front();
					n_digests++;
					check_field("digest_word0", exp_d.digest_word0, digest.digest_word0);
					check_field("digest_word1", exp_d.digest_word1, digest.digest_word1);
					check_field("digest_word2", exp_d.digest_word2, digest.digest_word2);
					check_field("digest_word3", exp_d.digest_word3, digest.digest_word3);
					check_field("digest_word4", exp_d.digest_word4, digest.digest_word4);
				end
			end
			if (start && !busy) begin
				n_words++;
				if (item.start_message) begin
					for (int i = 0; i < CHAIN_DEPTH; i++) chain_h[i] = INIT_H[i];
					fill = '0;
				end
				msg_win[fill] = item.message_word;
				fill = fill + 4'd1;
				if (fill == '0) begin
					compress_window();
					exp_d.digest_word0 = chain_h[0];
					exp_d.digest_word1 = chain_h[1];
					exp_d.digest_word2 = chain_h[2];
					exp_d.digest_word3 = chain_h[3];
					exp_d.digest_word4 = chain_h[4];
					digest_queue.push_back(exp_d);
				end
			end
		end
		pending <= digest_queue.size();
		fail_count <= fails;
		words_seen <= n_words;
		digests_seen <= n_digests;
	end

endmodule

/* tb/tb.sv */
// Top of the testbench for sha1_block_compression: clock, reset and word stimulus.
// Sends directed and random message words; sha1c_checker gives the verdict data.
// Depends on sha1c_pkg, sha1_block_compression and sha1c_checker.
`timescale 1ns / 1ps

module tb;

	import sha1c_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	sha1c_in_t  item = '0;
	logic       busy;
	logic       done;
	sha1c_out_t digest;

	int  fail_count, pending, words_seen, digests_seen;
	int  cycle_count = 0;
	bit  idle_on = 1'b1;
	int  random_words = 0;
	int  msg_count = 0;
	int  cut_count = 0;

	always #6 clk = ~clk;

	sha1_block_compression u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.digest (digest)
	);

	sha1c_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.digest       (digest),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_seen   (words_seen),
		.digests_seen (digests_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d digests outstanding.",
				cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w, input logic s);
		while (idle_on && $urandom_range(99) < 25) begin
			start <= 1'b0;
			item.message_word <= $urandom;
			item.start_message <= 1'($urandom_range(1));
			@(posedge clk);
		end
		start <= 1'b1;
		item.message_word <= w;
		item.start_message <= s;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n_blocks, n_words;
		bit chain_only, cut_short;
		logic s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A block sent before any start chains from the reset value.
		for (int i = 0; i < 16; i++) send_word(i[0] ? '1 : '0, 1'b0);
		drain();
		// A message cut short by a start in mid-block.
		send_word(32'h80000000, 1'b1);
		send_word(32'h00000001, 1'b0);
		send_word(32'hffffffff, 1'b0);
		send_word(32'h12345678, 1'b1);

		while (random_words < 430) begin
			idle_on = !(msg_count >= 8 && msg_count < 14);
			n_blocks = $urandom_range(1, 3);
			chain_only = ($urandom_range(9) == 0);
			cut_short = ($urandom_range(7) == 0);
			n_words = cut_short ? $urandom_range(1, 15) : 16 * n_blocks;
			for (int i = 0; i < n_words; i++) begin
				s = (i == 0) && !chain_only;
				if (cut_short && $urandom_range(3) == 0) s = 1'($urandom_range(1));
				send_word(pick_word(), s);
				random_words++;
			end
			msg_count++;
			if (cut_short) cut_count++;
			if ($urandom_range(19) == 0) drain();
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d words in %0d random messages (%0d cut short in mid-block),",
			words_seen, msg_count, cut_count);
		$display("and checked %0d block digests against the predicted chaining value.",
			digests_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
